// ===== src/sxs_pkg.sv =====
package sxs_pkg;

   localparam int unsigned SCORE_W = 16;
   localparam int unsigned ARRIVAL_W = 6;

   typedef struct packed {
      logic signed [SCORE_W-1:0] entry_score;
      logic                      final_entry;
   } req_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] sorted_score;
      logic [ARRIVAL_W-1:0]      arrival_index;
      logic                      end_of_group;
      logic                      overflowed;
   } rsp_type;

   // one store entry: score and the arrival tag that travels with it
   typedef struct packed {
      logic signed [SCORE_W-1:0] key;
      logic [ARRIVAL_W-1:0]      tag;
   } entry_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_P_READ,
      ST_P_LATCH,
      ST_Q_READ,
      ST_Q_CMP,
      ST_P_WRITE,
      ST_EMIT_READ,
      ST_EMIT_LOAD
   } state_type;

endpackage

// ===== src/score_exchange_sort.sv =====
// channel | ports                          | direction | payload
// --------+--------------------------------+-----------+--------------------------------
// request | req_valid, req_stall, req_data | in        | entry_score, final_entry
// response| rsp_valid, rsp_stall, rsp_data | out       | sorted_score, arrival_index,
//         |                                |           | end_of_group, overflowed
//
// load takes one transfer per cycle; a group then sorts by compare-swaps:
// every compare-swap is one read and one compare of the single store memory
// (registered read port), and each pivot adds a read and a write. emission
// reads each result, then loads it into the output register. reset is
// synchronous, active high, and clears control state only. req_stall is high
// from the final transfer until the last result of the group sits in the
// output register; a stalled response holds it and the emission sequence waits.
module score_exchange_sort #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sxs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sxs_pkg::rsp_type rsp_data
);
   import sxs_pkg::*;

   localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(ENTRIES);
   localparam logic [CW-1:0] ONE = CW'(1);

   // entry store, one write port and one registered read port
   entry_type entry_mem [ENTRIES];

   state_type        state_ff, state_in;
   logic [CW-1:0]    fill_ff, fill_in;      // entries held; group size during sort
   logic             ovf_ff, ovf_in;
   logic [AW-1:0]    p_ff, p_in;            // pivot position
   logic [AW-1:0]    q_ff, q_in;            // scan position
   logic [AW-1:0]    k_ff, k_in;            // emit position
   entry_type        pivot_ff, pivot_in;
   entry_type        rd_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             mem_we;
   logic [AW-1:0]    mem_wa;
   entry_type        mem_wd;
   logic             mem_re;
   logic [AW-1:0]    mem_ra;

   logic             req_fire;
   logic             out_free;
   logic             has_room;
   logic [CW-1:0]    group_n;               // group size after the final transfer

   assign req_stall = (state_ff != ST_LOAD);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign has_room  = (fill_ff < FULL);
   assign group_n   = has_room ? fill_ff + ONE : fill_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_data.final_entry) begin
               state_in = (group_n == ONE) ? ST_EMIT_READ : ST_P_READ;
            end
         end
         ST_P_READ:  state_in = ST_P_LATCH;
         ST_P_LATCH: state_in = ST_Q_READ;
         ST_Q_READ:  state_in = ST_Q_CMP;
         ST_Q_CMP: begin
            state_in = (CW'(q_ff) + ONE == fill_ff) ? ST_P_WRITE : ST_Q_READ;
         end
         ST_P_WRITE: begin
            // the last position needs no pass of its own
            state_in = (CW'(p_ff) + CW'(2) == fill_ff) ? ST_EMIT_READ : ST_P_READ;
         end
         ST_EMIT_READ: state_in = ST_EMIT_LOAD;
         ST_EMIT_LOAD: begin
            // once the result is taken, read the next position or finish the group
            if (out_free) begin
               state_in = (CW'(k_ff) + ONE == fill_ff) ? ST_LOAD : ST_EMIT_READ;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // datapath control
   always_comb begin
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      k_in         = k_ff;
      pivot_in     = pivot_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_wa       = fill_ff[AW-1:0];
      mem_wd       = pivot_ff;
      mem_re       = 1'b0;
      mem_ra       = p_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (has_room) begin
                  mem_we     = 1'b1;
                  mem_wa     = fill_ff[AW-1:0];
                  mem_wd.key = req_data.entry_score;
                  mem_wd.tag = ARRIVAL_W'(fill_ff);
                  fill_in    = fill_ff + ONE;
               end else begin
                  ovf_in = 1'b1;
               end
               p_in = '0;
               k_in = '0;
            end
         end
         ST_P_READ: begin
            mem_re = 1'b1;
            mem_ra = p_ff;
         end
         ST_P_LATCH: begin
            pivot_in = rd_data_ff;
            q_in     = p_ff + AW'(1);
         end
         ST_Q_READ: begin
            mem_re = 1'b1;
            mem_ra = q_ff;
         end
         ST_Q_CMP: begin
            // strictly greater swaps, so an equal entry does not displace the pivot
            if (rd_data_ff.key > pivot_ff.key) begin
               mem_we   = 1'b1;
               mem_wa   = q_ff;
               mem_wd   = pivot_ff;
               pivot_in = rd_data_ff;
            end
            q_in = q_ff + AW'(1);
         end
         ST_P_WRITE: begin
            mem_we = 1'b1;
            mem_wa = p_ff;
            mem_wd = pivot_ff;
            p_in   = p_ff + AW'(1);
         end
         ST_EMIT_READ: begin
            mem_re = 1'b1;
            mem_ra = k_ff;
         end
         ST_EMIT_LOAD: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.sorted_score  = rd_data_ff.key;
               rsp_data_in.arrival_index = rd_data_ff.tag;
               rsp_data_in.end_of_group  = (CW'(k_ff) + ONE == fill_ff);
               rsp_data_in.overflowed    = ovf_ff;
               k_in                      = k_ff + AW'(1);
               if (CW'(k_ff) + ONE == fill_ff) begin
                  fill_in = '0;
                  ovf_in  = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // store memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem[mem_ra];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      q_ff        <= q_in;
      k_ff        <= k_in;
      pivot_ff    <= pivot_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // the fill count never passes capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL)
      else $error("fill count above capacity");

   // a transfer into a full store marks the group as overflowed
   a_drop_marks: assert property (@(posedge clock) disable iff (reset)
      req_fire && !has_room |=> ovf_ff)
      else $error("dropped entry not flagged");

   // the scan position always lies past the pivot
   a_scan_after_pivot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_READ || state_ff == ST_Q_CMP) |-> q_ff > p_ff)
      else $error("scan position not after pivot");

   // the end of a group leaves an empty, unflagged store behind
   a_group_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_LOAD && state_in == ST_LOAD |=> fill_ff == '0 && !ovf_ff)
      else $error("group state not cleared");
`endif

endmodule
